// File: rtl/stt_pkg.sv
// Shared types and constants for the source text tokenizer.
`default_nettype none

package stt_pkg;

	localparam int unsigned POSITION_BITS_DEFAULT = 16;
	localparam int unsigned RES_DEPTH = 4;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_OP,
		MODE_COMMENT,
		MODE_STRING,
		MODE_NUMBER,
		MODE_IDENT
	} mode_t;

	localparam logic [5:0] K_LEFT_PAREN    = 6'd0;
	localparam logic [5:0] K_RIGHT_PAREN   = 6'd1;
	localparam logic [5:0] K_LEFT_BRACE    = 6'd2;
	localparam logic [5:0] K_RIGHT_BRACE   = 6'd3;
	localparam logic [5:0] K_SEMICOLON     = 6'd4;
	localparam logic [5:0] K_COLON         = 6'd5;
	localparam logic [5:0] K_BANG_EQUAL    = 6'd6;
	localparam logic [5:0] K_BANG          = 6'd7;
	localparam logic [5:0] K_EQUAL_EQUAL   = 6'd8;
	localparam logic [5:0] K_EQUAL         = 6'd9;
	localparam logic [5:0] K_GREATER_EQUAL = 6'd10;
	localparam logic [5:0] K_GREATER       = 6'd11;
	localparam logic [5:0] K_LESS_EQUAL    = 6'd12;
	localparam logic [5:0] K_LESS          = 6'd13;
	localparam logic [5:0] K_PLUS_EQUAL    = 6'd14;
	localparam logic [5:0] K_PLUS          = 6'd15;
	localparam logic [5:0] K_MINUS_EQUAL   = 6'd16;
	localparam logic [5:0] K_MINUS         = 6'd17;
	localparam logic [5:0] K_SLASH_EQUAL   = 6'd18;
	localparam logic [5:0] K_COMMENT       = 6'd19;
	localparam logic [5:0] K_SLASH         = 6'd20;
	localparam logic [5:0] K_STAR_EQUAL    = 6'd21;
	localparam logic [5:0] K_STAR          = 6'd22;
	localparam logic [5:0] K_MODULO_EQUAL  = 6'd23;
	localparam logic [5:0] K_MODULO        = 6'd24;
	localparam logic [5:0] K_AND           = 6'd25;
	localparam logic [5:0] K_OR            = 6'd26;
	localparam logic [5:0] K_STRING        = 6'd27;
	localparam logic [5:0] K_EOF           = 6'd28;
	localparam logic [5:0] K_NUMBER        = 6'd29;
	localparam logic [5:0] K_IDENTIFIER    = 6'd30;
	localparam logic [5:0] K_FN            = 6'd31;
	localparam logic [5:0] K_RETURN        = 6'd32;

	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
	localparam logic [1:0] ERR_UNTERM_STR = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW   = 2'd3;

	localparam logic [47:0] WORD_FN     = 48'h0000_0000_666E;
	localparam logic [47:0] WORD_RETURN = 48'h7265_7475_726E;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic [1:0]  err;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// File: rtl/source_text_tokenizer.sv
// Byte-serial lexer: one source byte in, up to two token words out.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------------------
//  byte    | byte_valid  | byte_stall  | in_byte
//  token   | token_valid | token_stall | token_kind token_start token_length
//          |             |             | line_number error_code last_result
//
// One byte is taken per cycle unless byte_stall is high. A byte is held in the input
// register, where the scan state is updated and its zero, one or two token words are
// written into a four-entry result queue, whose head word is shown on the token side.
// The byte side stalls while the queue has fewer than two free entries, so a run of
// bytes that each give two words is held to the rate at which words are taken.
// arst_n clears the scan state, the input register and the queue.
`default_nettype none

module source_text_tokenizer #(
	parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  in_byte,
	output logic             token_valid,
	input  wire logic        token_stall,
	output logic [5:0]       token_kind,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic [15:0]      line_number,
	output logic [1:0]       error_code,
	output logic             last_result
);
	import stt_pkg::*;

	localparam int unsigned P = POSITION_BITS;
	localparam logic [P-1:0] POS_MAX = {P{1'b1}};
	localparam logic [P-1:0] POS_ONE = P'(1);
	localparam int unsigned PTR_W = $clog2(RES_DEPTH);
	localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(RES_DEPTH - 2);

	// scan state
	mode_t        mode_q;
	logic [P-1:0] pos_q;
	logic [P-1:0] start_q;
	logic [15:0]  line_q;
	logic [7:0]   op_q;
	logic [47:0]  kw_q;
	logic         dot_q;
	logic         halt_q;

	mode_t        mode_d;
	logic [P-1:0] pos_d;
	logic [P-1:0] start_d;
	logic [15:0]  line_d;
	logic [7:0]   op_d;
	logic [47:0]  kw_d;
	logic         dot_d;
	logic         halt_d;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result queue
	res_t             fifo_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	res_t       res [2];
	logic [1:0] res_n;
	logic       consume;
	logic       pop;
	logic       byte_acc;

	function automatic logic [5:0] op_kind(input logic [7:0] p, input logic with_eq);
		logic [5:0] k;
		case (p)
			8'h21:   k = with_eq ? K_BANG_EQUAL : K_BANG;
			8'h3D:   k = with_eq ? K_EQUAL_EQUAL : K_EQUAL;
			8'h3E:   k = with_eq ? K_GREATER_EQUAL : K_GREATER;
			8'h3C:   k = with_eq ? K_LESS_EQUAL : K_LESS;
			8'h2B:   k = with_eq ? K_PLUS_EQUAL : K_PLUS;
			8'h2D:   k = with_eq ? K_MINUS_EQUAL : K_MINUS;
			8'h2F:   k = with_eq ? K_SLASH_EQUAL : K_SLASH;
			8'h2A:   k = with_eq ? K_STAR_EQUAL : K_STAR;
			default: k = with_eq ? K_MODULO_EQUAL : K_MODULO;
		endcase
		return k;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			is_digit(c) || (c == CH_UNDER);
	endfunction

	function automatic res_t mk(input logic [5:0] kind, input logic [P-1:0] start,
		input logic [P-1:0] len, input logic [15:0] line, input logic [1:0] err);
		res_t r;
		r.kind   = kind;
		r.start  = 16'(start);
		r.length = 16'(len);
		r.line   = line;
		r.err    = err;
		r.last   = 1'b0;
		return r;
	endfunction

	assign consume    = valid_s1 && (cnt_q <= CNT_ROOM);
	assign byte_stall = valid_s1 && !consume;
	assign byte_acc   = byte_valid && !byte_stall;
	assign pop        = token_valid && !token_stall;

	always_comb begin
		logic [7:0]   c;
		logic         idle_go;
		logic         do_restart;
		logic [P-1:0] len;
		logic [5:0]   k;
		c          = byte_s1;
		idle_go    = 1'b0;
		do_restart = 1'b0;
		len        = pos_q - start_q;
		k          = K_IDENTIFIER;
		mode_d     = mode_q;
		pos_d      = pos_q;
		start_d    = start_q;
		line_d     = line_q;
		op_d       = op_q;
		kw_d       = kw_q;
		dot_d      = dot_q;
		halt_d     = halt_q;
		res[0]     = '0;
		res[1]     = '0;
		res_n      = 2'd0;

		if (halt_q) begin
			do_restart = (c == CH_NUL);
		end else if ((c != CH_NUL) && (pos_q == POS_MAX)) begin
			mode_d = MODE_IDLE;
			res[0] = mk(6'd0, POS_MAX, '0, line_q, ERR_OVERFLOW);
			res_n  = 2'd1;
			halt_d = 1'b1;
		end else begin
			case (mode_q)
				MODE_OP: begin
					if ((op_q == CH_AMP) || (op_q == CH_BAR)) begin
						mode_d = MODE_IDLE;
						if (c == op_q) begin
							res[0] = mk((op_q == CH_AMP) ? K_AND : K_OR, start_q,
								P'(2), line_q, ERR_NONE);
							pos_d  = pos_q + POS_ONE;
						end else begin
							res[0] = mk(6'd0, start_q, '0, line_q, ERR_UNEXPECTED);
							if (c == CH_NUL) do_restart = 1'b1;
							else halt_d = 1'b1;
						end
						res_n = 2'd1;
					end else if ((op_q == CH_SLASH) && (c == CH_SLASH)) begin
						mode_d = MODE_COMMENT;
						pos_d  = pos_q + POS_ONE;
					end else if (c == CH_EQUAL) begin
						res[0] = mk(op_kind(op_q, 1'b1), start_q, P'(2), line_q, ERR_NONE);
						res_n  = 2'd1;
						mode_d = MODE_IDLE;
						pos_d  = pos_q + POS_ONE;
					end else begin
						res[0]  = mk(op_kind(op_q, 1'b0), start_q, POS_ONE, line_q, ERR_NONE);
						res_n   = 2'd1;
						idle_go = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if ((c == CH_NEWLINE) || (c == CH_NUL)) begin
						res[0]  = mk(K_COMMENT, start_q, '0, line_q, ERR_NONE);
						res_n   = 2'd1;
						idle_go = 1'b1;
					end else begin
						pos_d = pos_q + POS_ONE;
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE) begin
						res[0] = mk(K_STRING, start_q, len, line_q, ERR_NONE);
						res_n  = 2'd1;
						mode_d = MODE_IDLE;
						pos_d  = pos_q + POS_ONE;
					end else if (c == CH_NUL) begin
						res[0]     = mk(6'd0, start_q, '0, line_q, ERR_UNTERM_STR);
						res_n      = 2'd1;
						do_restart = 1'b1;
					end else begin
						pos_d = pos_q + POS_ONE;
					end
				end
				MODE_NUMBER: begin
					if (dot_q) begin
						if (is_digit(c)) begin
							dot_d = 1'b0;
							pos_d = pos_q + POS_ONE;
						end else begin
							// the dot had no digit after it: close the number, flag the dot
							res[0] = mk(K_NUMBER, start_q, len - POS_ONE, line_q, ERR_NONE);
							res[1] = mk(6'd0, pos_q - POS_ONE, '0, line_q, ERR_UNEXPECTED);
							res_n  = 2'd2;
							mode_d = MODE_IDLE;
							dot_d  = 1'b0;
							if (c == CH_NUL) do_restart = 1'b1;
							else halt_d = 1'b1;
						end
					end else if (is_digit(c)) begin
						pos_d = pos_q + POS_ONE;
					end else if (c == CH_DOT) begin
						dot_d = 1'b1;
						pos_d = pos_q + POS_ONE;
					end else begin
						res[0]  = mk(K_NUMBER, start_q, len, line_q, ERR_NONE);
						res_n   = 2'd1;
						idle_go = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_word(c)) begin
						if (len < P'(6)) kw_d = {kw_q[39:0], c};
						pos_d = pos_q + POS_ONE;
					end else begin
						if ((len == P'(2)) && (kw_q == WORD_FN)) k = K_FN;
						else if ((len == P'(6)) && (kw_q == WORD_RETURN)) k = K_RETURN;
						res[0]  = mk(k, start_q, len, line_q, ERR_NONE);
						res_n   = 2'd1;
						idle_go = 1'b1;
					end
				end
				default: idle_go = 1'b1;
			endcase
		end

		// between tokens; no earlier arm moved the position or the line
		if (idle_go) begin
			mode_d = MODE_IDLE;
			pos_d  = pos_q + POS_ONE;
			case (c) inside
				8'h28: res[res_n[0]] = mk(K_LEFT_PAREN, pos_q, POS_ONE, line_q, ERR_NONE);
				8'h29: res[res_n[0]] = mk(K_RIGHT_PAREN, pos_q, POS_ONE, line_q, ERR_NONE);
				8'h7B: res[res_n[0]] = mk(K_LEFT_BRACE, pos_q, POS_ONE, line_q, ERR_NONE);
				8'h7D: res[res_n[0]] = mk(K_RIGHT_BRACE, pos_q, POS_ONE, line_q, ERR_NONE);
				8'h3B: res[res_n[0]] = mk(K_SEMICOLON, pos_q, POS_ONE, line_q, ERR_NONE);
				8'h3A: res[res_n[0]] = mk(K_COLON, pos_q, POS_ONE, line_q, ERR_NONE);
				CH_NUL: begin
					res[res_n[0]] = mk(K_EOF, pos_q, '0, line_q, ERR_NONE);
					do_restart    = 1'b1;
				end
				[8'h09:8'h0D], 8'h20: begin
					if ((c == CH_NEWLINE) && (line_q != 16'hFFFF)) line_d = line_q + 16'd1;
				end
				8'h21, 8'h3D, 8'h3E, 8'h3C, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h25,
				CH_AMP, CH_BAR: begin
					mode_d  = MODE_OP;
					op_d    = c;
					start_d = pos_q;
				end
				CH_QUOTE: begin
					mode_d  = MODE_STRING;
					start_d = pos_q + POS_ONE;
				end
				[8'h30:8'h39]: begin
					mode_d  = MODE_NUMBER;
					dot_d   = 1'b0;
					start_d = pos_q;
				end
				[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER: begin
					mode_d  = MODE_IDENT;
					kw_d    = {40'd0, c};
					start_d = pos_q;
				end
				default: begin
					res[res_n[0]] = mk(6'd0, pos_q, '0, line_q, ERR_UNEXPECTED);
					pos_d         = pos_q;
					halt_d        = 1'b1;
				end
			endcase
			// every arm but whitespace and the start of a multi-byte lexeme gives a word
			case (c) inside
				[8'h09:8'h0D], 8'h20, 8'h21, 8'h3D, 8'h3E, 8'h3C, 8'h2B, 8'h2D, 8'h2F,
				8'h2A, 8'h25, CH_AMP, CH_BAR, CH_QUOTE, [8'h30:8'h39], [8'h41:8'h5A],
				[8'h61:8'h7A], CH_UNDER: ;
				default: res_n = res_n + 2'd1;
			endcase
		end

		if (do_restart) begin
			mode_d  = MODE_IDLE;
			pos_d   = '0;
			start_d = '0;
			line_d  = 16'd1;
			op_d    = '0;
			kw_d    = '0;
			dot_d   = 1'b0;
			halt_d  = 1'b0;
		end

		if (res_n == 2'd2) res[1].last = 1'b1;
		else res[0].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			line_q   <= 16'd1;
			op_q     <= '0;
			kw_q     <= '0;
			dot_q    <= 1'b0;
			halt_q   <= 1'b0;
			valid_s1 <= 1'b0;
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (byte_acc) valid_s1 <= 1'b1;
			else if (consume) valid_s1 <= 1'b0;
			if (consume) begin
				mode_q  <= mode_d;
				pos_q   <= pos_d;
				start_q <= start_d;
				line_q  <= line_d;
				op_q    <= op_d;
				kw_q    <= kw_d;
				dot_q   <= dot_d;
				halt_q  <= halt_d;
				wr_q    <= wr_q + PTR_W'(res_n);
			end
			if (pop) rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (consume ? CNT_W'(res_n) : '0) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) byte_s1 <= in_byte;
		if (consume) begin
			if (res_n != 2'd0) fifo_q[wr_q] <= res[0];
			if (res_n == 2'd2) fifo_q[wr_q + PTR_W'(1)] <= res[1];
		end
	end

	// hold the head word until it is taken
	assign token_valid  = (cnt_q != '0);
	assign token_kind   = fifo_q[rd_q].kind;
	assign token_start  = fifo_q[rd_q].start;
	assign token_length = fifo_q[rd_q].length;
	assign line_number  = fifo_q[rd_q].line;
	assign error_code   = fifo_q[rd_q].err;
	assign last_result  = fifo_q[rd_q].last;

endmodule

`default_nettype wire

// File: rtl/stt_checker.sv
// Port-level checks for the source text tokenizer, bound to its top level.
`default_nettype none

module stt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        token_valid,
	input wire logic        token_stall,
	input wire logic [5:0]  token_kind,
	input wire logic [15:0] token_start,
	input wire logic [15:0] token_length,
	input wire logic [15:0] line_number,
	input wire logic [1:0]  error_code,
	input wire logic        last_result
);
	import stt_pkg::*;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_kind) &&
		$stable(token_start) && $stable(token_length) && $stable(error_code) &&
		$stable(last_result))
		else $error("stalled token word changed");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (error_code != ERR_NONE) |-> (token_kind == K_LEFT_PAREN) &&
		(token_length == 16'd0) && last_result)
		else $error("error word with kind, length or without last mark");

	a_eof_word: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == K_EOF) && (error_code == ERR_NONE) |->
		last_result && (token_length == 16'd0))
		else $error("end word malformed");

	a_line: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> (line_number != 16'd0) && (token_kind <= K_RETURN))
		else $error("line number zero or kind out of range");

	// the overflow word points at the last position, never at zero
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (error_code == ERR_OVERFLOW) |-> (token_start != 16'd0))
		else $error("overflow word at a zero offset");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);

`default_nettype wire

// File: sim/tb_source_text_tokenizer.sv
`timescale 1ns / 100ps
// Testbench for source_text_tokenizer: byte stream in, token words checked against a lexer model.
module tb_source_text_tokenizer;
	import stt_pkg::*;

	localparam logic [5:0]  KIND_NONE = 6'd0;
	localparam logic [15:0] POS_LAST  = 16'hFFFF;
	localparam logic [15:0] LINE_MAX  = 16'hFFFF;

	typedef struct packed {
		logic [7:0] ch;
		logic       known;
		res_t       word;
	} stim_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] line_number;
	logic [1:0]  error_code;
	logic        last_result;

	always #5 clk = ~clk;

	source_text_tokenizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.in_byte      (in_byte),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.line_number  (line_number),
		.error_code   (error_code),
		.last_result  (last_result)
	);

	// lexer model state
	mode_t       scan_st;
	logic [15:0] scan_pos;
	logic [15:0] tok_begin;
	logic [15:0] line_cnt;
	logic [7:0]  op_char;
	logic [47:0] id_word;
	bit          dot_wait;
	bit          halted;
	res_t        want_tokens[$];

	stim_t       byte_q[$];
	stim_t       dir_rows[$];
	stim_t       cur_stim;
	stim_t       next_stim;
	res_t        got_word;
	int unsigned q_mark;
	int unsigned live_bytes = 0;
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	int unsigned mismatches = 0;
	bit          hold_send = 1'b0;

	string punct_set = "(){};:";
	string op_set    = "!=><+-/*%";
	string ws_set    = " \t\n\v\f\r";
	string id_set    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string junk_set  = "@#$\\`~[],'?.";

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_op_char(logic [7:0] c);
		case (c)
		"!", "=", ">", "<", "+", "-", "/", "*", "%", CH_AMP, CH_BAR: return 1'b1;
		default: return 1'b0;
		endcase
	endfunction

	function automatic logic [5:0] op_token(logic [7:0] op, bit with_eq);
		case (op)
		"!": return with_eq ? K_BANG_EQUAL : K_BANG;
		"=": return with_eq ? K_EQUAL_EQUAL : K_EQUAL;
		">": return with_eq ? K_GREATER_EQUAL : K_GREATER;
		"<": return with_eq ? K_LESS_EQUAL : K_LESS;
		"+": return with_eq ? K_PLUS_EQUAL : K_PLUS;
		"-": return with_eq ? K_MINUS_EQUAL : K_MINUS;
		"/": return with_eq ? K_SLASH_EQUAL : K_SLASH;
		"*": return with_eq ? K_STAR_EQUAL : K_STAR;
		default: return with_eq ? K_MODULO_EQUAL : K_MODULO;
		endcase
	endfunction

	function automatic stim_t row_plain(logic [7:0] c);
		stim_t s;
		s = '0;
		s.ch = c;
		return s;
	endfunction

	function automatic stim_t row_known(logic [7:0] c, logic [5:0] kind, logic [15:0] start,
			logic [15:0] len, logic [15:0] line, logic [1:0] err);
		stim_t s;
		s = '0;
		s.ch = c;
		s.known = 1'b1;
		s.word.kind = kind;
		s.word.start = start;
		s.word.length = len;
		s.word.line = line;
		s.word.err = err;
		s.word.last = 1'b1;
		return s;
	endfunction

	task automatic lexer_restart();
		scan_st = MODE_IDLE;
		scan_pos = '0;
		tok_begin = '0;
		line_cnt = 16'd1;
		op_char = '0;
		id_word = '0;
		dot_wait = 1'b0;
		halted = 1'b0;
	endtask

	task automatic push_token(logic [5:0] kind, logic [15:0] start, logic [15:0] len,
			logic [1:0] err);
		res_t w;
		w.kind = kind;
		w.start = start;
		w.length = len;
		w.line = line_cnt;
		w.err = err;
		w.last = 1'b0;
		want_tokens.insert(want_tokens.size(), w);
	endtask

	task automatic lex_fail(logic [15:0] where, logic [1:0] err, logic [7:0] c);
		push_token(KIND_NONE, where, 16'd0, err);
		if (c == CH_NUL)
			lexer_restart();
		else
			halted = 1'b1;
	endtask

	// Handle a byte that arrives between tokens.
	task automatic lex_idle(logic [7:0] c);
		logic [5:0] kind;
		bit punct;
		bit advance;
		punct = 1'b1;
		advance = 1'b1;
		kind = KIND_NONE;
		scan_st = MODE_IDLE;
		case (c)
		"(": kind = K_LEFT_PAREN;
		")": kind = K_RIGHT_PAREN;
		"{": kind = K_LEFT_BRACE;
		"}": kind = K_RIGHT_BRACE;
		";": kind = K_SEMICOLON;
		":": kind = K_COLON;
		default: punct = 1'b0;
		endcase
		if (punct) begin
			push_token(kind, scan_pos, 16'd1, ERR_NONE);
		end else if (c == CH_NUL) begin
			push_token(K_EOF, scan_pos, 16'd0, ERR_NONE);
			lexer_restart();
			advance = 1'b0;
		end else if (is_space(c)) begin
			if (c == CH_NEWLINE && line_cnt != LINE_MAX)
				line_cnt++;
		end else if (is_op_char(c)) begin
			scan_st = MODE_OP;
			op_char = c;
			tok_begin = scan_pos;
		end else if (c == CH_QUOTE) begin
			scan_st = MODE_STRING;
			tok_begin = scan_pos + 16'd1;
		end else if (is_digit(c)) begin
			scan_st = MODE_NUMBER;
			dot_wait = 1'b0;
			tok_begin = scan_pos;
		end else if (is_alpha(c) || c == CH_UNDER) begin
			scan_st = MODE_IDENT;
			id_word = {40'd0, c};
			tok_begin = scan_pos;
		end else begin
			lex_fail(scan_pos, ERR_UNEXPECTED, c);
			advance = 1'b0;
		end
		if (advance)
			scan_pos++;
	endtask

	// Advance the lexer model by one byte and queue the words it causes.
	task automatic lex_byte(logic [7:0] c);
		int unsigned n0;
		logic [15:0] len;
		logic [5:0] kind;
		n0 = want_tokens.size();
		if (halted) begin
			if (c == CH_NUL)
				lexer_restart();
		end else if (c != CH_NUL && scan_pos == POS_LAST) begin
			// drop whatever token is pending
			scan_st = MODE_IDLE;
			push_token(KIND_NONE, POS_LAST, 16'd0, ERR_OVERFLOW);
			halted = 1'b1;
		end else begin
			case (scan_st)
			MODE_OP: begin
				if (op_char == CH_AMP || op_char == CH_BAR) begin
					if (c == op_char) begin
						push_token(op_char == CH_AMP ? K_AND : K_OR, tok_begin, 16'd2, ERR_NONE);
						scan_st = MODE_IDLE;
						scan_pos++;
					end else begin
						scan_st = MODE_IDLE;
						lex_fail(tok_begin, ERR_UNEXPECTED, c);
					end
				end else if (op_char == CH_SLASH && c == CH_SLASH) begin
					scan_st = MODE_COMMENT;
					scan_pos++;
				end else if (c == CH_EQUAL) begin
					push_token(op_token(op_char, 1'b1), tok_begin, 16'd2, ERR_NONE);
					scan_st = MODE_IDLE;
					scan_pos++;
				end else begin
					push_token(op_token(op_char, 1'b0), tok_begin, 16'd1, ERR_NONE);
					lex_idle(c);
				end
			end
			MODE_COMMENT: begin
				if (c == CH_NEWLINE || c == CH_NUL) begin
					push_token(K_COMMENT, tok_begin, 16'd0, ERR_NONE);
					lex_idle(c);
				end else begin
					scan_pos++;
				end
			end
			MODE_STRING: begin
				if (c == CH_QUOTE) begin
					push_token(K_STRING, tok_begin, scan_pos - tok_begin, ERR_NONE);
					scan_st = MODE_IDLE;
					scan_pos++;
				end else if (c == CH_NUL) begin
					lex_fail(tok_begin, ERR_UNTERM_STR, c);
				end else begin
					scan_pos++;
				end
			end
			MODE_NUMBER: begin
				if (dot_wait) begin
					if (is_digit(c)) begin
						dot_wait = 1'b0;
						scan_pos++;
					end else begin
						// emit the number without its dot, then flag the dot
						push_token(K_NUMBER, tok_begin, scan_pos - 16'd1 - tok_begin, ERR_NONE);
						scan_st = MODE_IDLE;
						dot_wait = 1'b0;
						lex_fail(scan_pos - 16'd1, ERR_UNEXPECTED, c);
					end
				end else if (is_digit(c)) begin
					scan_pos++;
				end else if (c == CH_DOT) begin
					dot_wait = 1'b1;
					scan_pos++;
				end else begin
					push_token(K_NUMBER, tok_begin, scan_pos - tok_begin, ERR_NONE);
					lex_idle(c);
				end
			end
			MODE_IDENT: begin
				len = scan_pos - tok_begin;
				if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
					if (len < 16'd6)
						id_word = {id_word[39:0], c};
					scan_pos++;
				end else begin
					kind = K_IDENTIFIER;
					if (len == 16'd2 && id_word == WORD_FN)
						kind = K_FN;
					else if (len == 16'd6 && id_word == WORD_RETURN)
						kind = K_RETURN;
					push_token(kind, tok_begin, len, ERR_NONE);
					lex_idle(c);
				end
			end
			default: lex_idle(c);
			endcase
		end
		if (want_tokens.size() > n0)
			want_tokens[want_tokens.size() - 1].last = 1'b1;
	endtask

	task automatic push_ch(logic [7:0] c);
		byte_q.insert(byte_q.size(), row_plain(c));
	endtask

	task automatic push_str(string t);
		for (int i = 0; i < t.len(); i++)
			push_ch(t[i]);
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Mostly well-formed texts with random content, a few broken ones mixed in.
	task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned target);
		int unsigned goal;
		int unsigned r;
		int unsigned k;
		logic [7:0] c;
		bit paused;
		@(posedge clk);
		send_idle <= idle_pct;
		recv_stall <= stall_pct;
		goal = live_bytes + target;
		paused = 1'b0;
		while (live_bytes < goal) begin
			repeat ($urandom_range(12, 1)) begin
				r = $urandom_range(99);
				if (r < 10) begin
					push_ch(punct_set[$urandom_range(5)]);
				end else if (r < 30) begin
					push_ch(op_set[$urandom_range(8)]);
					if ($urandom_range(1))
						push_ch(CH_EQUAL);
				end else if (r < 35) begin
					push_str($urandom_range(1) ? "&&" : "||");
				end else if (r < 42) begin
					push_str("//");
					repeat ($urandom_range(6)) push_ch(8'($urandom_range(126, 32)));
					if ($urandom_range(9) < 8)
						push_ch(CH_NEWLINE);
				end else if (r < 54) begin
					push_ch(CH_QUOTE);
					repeat ($urandom_range(8)) begin
						c = 8'($urandom_range(255, 1));
						push_ch(c == CH_QUOTE ? CH_NEWLINE : c);
					end
					push_ch(CH_QUOTE);
				end else if (r < 69) begin
					repeat ($urandom_range(4, 1)) push_ch(8'($urandom_range("9", "0")));
					if ($urandom_range(9) < 3) begin
						push_ch(CH_DOT);
						repeat ($urandom_range(3, 1)) push_ch(8'($urandom_range("9", "0")));
					end
				end else if (r < 90) begin
					k = $urandom_range(7);
					case (k)
					0: push_str("fn");
					1: push_str("return");
					2: push_str("retur");
					3: push_str("returned");
					4: push_str("fn_");
					default: begin
						push_ch(id_set[$urandom_range(52)]);
						repeat ($urandom_range(7)) push_ch(id_set[$urandom_range(62)]);
					end
					endcase
				end else if (r < 94) begin
					repeat ($urandom_range(4, 1)) push_ch(ws_set[$urandom_range(5)]);
				end else begin
					k = $urandom_range(5);
					case (k)
					0: push_str($urandom_range(1) ? "&x" : "|;");
					1: push_str("7.;");
					2: push_ch(junk_set[$urandom_range(11)]);
					3: push_ch(8'($urandom_range(255, 128)));
					4: push_str("\"ab");
					default: push_ch(8'($urandom_range(255, 1)));
					endcase
				end
				if ($urandom_range(99) < 60)
					push_ch(ws_set[$urandom_range(5)]);
			end
			push_ch(CH_NUL);
			if (!paused && live_bytes * 2 >= goal * 2 - target) begin
				// hold the sender until every pending word is out
				paused = 1'b1;
				@(posedge clk);
				hold_send <= 1'b1;
				@(posedge clk);
				while (byte_valid || want_tokens.size() != 0)
					@(posedge clk);
				hold_send <= 1'b0;
			end
			while (byte_q.size() != 0)
				@(posedge clk);
		end
	endtask

	// byte side: take accepted bytes into the model, then load the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				if (!halted)
					live_bytes++;
				q_mark = want_tokens.size();
				lex_byte(cur_stim.ch);
				if (cur_stim.known) begin
					while (want_tokens.size() > q_mark)
						void'(want_tokens.pop_back());
					want_tokens.insert(want_tokens.size(), cur_stim.word);
				end
			end
			if (!byte_valid || !byte_stall) begin
				if (byte_q.size() != 0 && !hold_send && $urandom_range(99) >= send_idle) begin
					next_stim = byte_q.pop_front();
					cur_stim <= next_stim;
					in_byte <= next_stim.ch;
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// token side: compare each accepted word with the oldest expected one
	always @(posedge clk) begin
		if (arst_n) begin
			if (token_valid && !token_stall) begin
				if (want_tokens.size() == 0) begin
					$display("%0t: token word with nothing expected: kind %0d start %0d err %0d",
						$time, token_kind, token_start, error_code);
					mismatches++;
				end else begin
					got_word = want_tokens.pop_front();
					check_field("token_kind", 16'(got_word.kind), 16'(token_kind));
					check_field("token_start", got_word.start, token_start);
					check_field("token_length", got_word.length, token_length);
					check_field("line_number", got_word.line, line_number);
					check_field("error_code", 16'(got_word.err), 16'(error_code));
					check_field("last_result", 16'(got_word.last), 16'(last_result));
				end
			end
			token_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	initial begin
		lexer_restart();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		dir_rows = '{
			row_known(";", K_SEMICOLON, 16'd0, 16'd1, 16'd1, ERR_NONE),
			row_known(CH_NUL, K_EOF, 16'd1, 16'd0, 16'd1, ERR_NONE),
			row_known("@", KIND_NONE, 16'd0, 16'd0, 16'd1, ERR_UNEXPECTED),
			row_plain("x"),
			row_plain(CH_NUL),
			row_plain(CH_QUOTE),
			row_plain("a"),
			row_known(CH_NUL, KIND_NONE, 16'd1, 16'd0, 16'd1, ERR_UNTERM_STR),
			row_known(8'hFF, KIND_NONE, 16'd0, 16'd0, 16'd1, ERR_UNEXPECTED),
			row_plain(CH_NUL),
			row_plain(CH_AMP),
			row_plain(CH_AMP),
			row_plain(CH_BAR),
			row_plain(CH_EQUAL),
			row_plain(CH_NUL),
			row_plain("1"),
			row_plain(CH_DOT),
			row_plain("x"),
			row_plain(CH_NUL),
			row_plain(CH_NEWLINE),
			row_plain("f"),
			row_plain("n"),
			row_plain(CH_SLASH),
			row_plain(CH_SLASH),
			row_plain(CH_NUL)
		};
		foreach (dir_rows[i])
			byte_q.insert(byte_q.size(), dir_rows[i]);
		while (byte_q.size() != 0)
			@(posedge clk);

		run_phase(0, 0, 250);
		run_phase(84, 0, 250);
		run_phase(0, 84, 250);
		run_phase(31, 31, 250);

		while (byte_q.size() != 0 || byte_valid || want_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_source_text_tokenizer: clean");
		else
			$display("tb_source_text_tokenizer: errors");
		$finish;
	end

	initial begin
		#(50_000_000);
		$display("tb_source_text_tokenizer: errors");
		$finish;
	end

endmodule

// File: sim.f
rtl/stt_pkg.sv
rtl/source_text_tokenizer.sv
rtl/stt_checker.sv
sim/tb_source_text_tokenizer.sv
